/* src/assert_macros.svh */
// Assertion macros used by the checked module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/cac_pkg.sv */
// Types and constants of the charge accumulator.
package cac_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } cac_state_t;

  typedef enum logic [1:0] {
    CFG_DISPLAY_RATIO = 2'd0,
    CFG_CHECKPOINT_INTERVAL = 2'd1,
    CFG_CHECKPOINT_TOLERANCE = 2'd2,
    CFG_HOLD_PERIODS = 2'd3
  } cac_cfg_index_t;

  localparam logic REQ_PERIOD = 1'b0;
  localparam logic REQ_RESTORE = 1'b1;

  localparam int CFG_DATA_W = 20;

  localparam logic [15:0] RESET_DISPLAY_RATIO = 16'd3600;
  localparam logic [19:0] RESET_CHECKPOINT_INTERVAL = 20'd36000;
  localparam logic [19:0] RESET_CHECKPOINT_TOLERANCE = 20'd1000;
  localparam logic [7:0] RESET_HOLD_PERIODS = 8'd3;

  localparam logic [15:0] HOURS_MAX = 16'hFFFF;
  localparam logic [7:0] HOLD_COUNT_MAX = 8'hFF;

  // Control of one bit-serial divider lane.
  typedef struct packed {
    logic clear;
    logic step;
    logic bit_in;
  } cac_div_ctl_t;

endpackage

/* src/cac_ifs.sv */
// Handshake channels of the charge accumulator: request, result and configuration.
interface cac_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [15:0] current;
  logic button_high;
  logic [31:0] saved_charge;
  logic saved_valid;

  modport source (output valid, req_type, current, button_high, saved_charge, saved_valid,
                  input ready);
  modport sink (input valid, req_type, current, button_high, saved_charge, saved_valid,
                output ready);
endinterface

interface cac_rsp_if;
  logic valid;
  logic ready;
  logic [15:0] hours_value;
  logic store_request;
  logic [31:0] store_value;
  logic cleared;

  modport source (output valid, hours_value, store_request, store_value, cleared,
                  input ready);
  modport sink (input valid, hours_value, store_request, store_value, cleared,
                output ready);
endinterface

interface cac_cfg_if;
  logic valid;
  logic ready;
  cac_pkg::cac_cfg_index_t index;
  logic [cac_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/charge_accumulator_with_checkpoint.sv */
// Top level of the charge accumulator with hold-to-clear and checkpoint requests.
//
//   channel  role    payload
//   req      sink    req_type, current, button_high, saved_charge, saved_valid
//   rsp      source  hours_value, store_request, store_value, cleared
//   cfg      sink    index, data (always ready)
//
// An item goes through an accept step that updates the charge, CHARGE_WIDTH steps of the
// two bit-serial divider lanes (display ratio and checkpoint interval), and a finishing
// step that tests the checkpoint and loads the result. The result sits in an output
// register; the next item is accepted meanwhile, and the finishing cycle holds until
// that register is free. Reset is synchronous and gives the register defaults and a
// zero charge, saved charge and hold count.
`include "assert_macros.svh"

module charge_accumulator_with_checkpoint #(
  parameter int CHARGE_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  cac_req_if.sink  req,
  cac_rsp_if.source rsp,
  cac_cfg_if.sink  cfg
);

  localparam int CNT_W = $clog2(CHARGE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHARGE_WIDTH - 1);
  localparam logic [CHARGE_WIDTH-1:0] CHARGE_MAX = '1;

  // configuration
  logic [15:0] display_ratio;
  logic [19:0] checkpoint_interval;
  logic [19:0] checkpoint_tolerance;
  logic [7:0]  hold_periods;

  // block state
  cac_pkg::cac_state_t state, state_next;
  logic [CHARGE_WIDTH-1:0] charge;
  logic [CHARGE_WIDTH-1:0] last_saved;
  logic [7:0]              hold_count;
  logic                    is_period;
  logic                    clr;
  logic [CNT_W-1:0]        bit_cnt;
  logic [CHARGE_WIDTH-1:0] shreg;
  logic [15:0]             quo;
  logic                    quo_ovf;
  logic [CHARGE_WIDTH-1:0] gap;
  logic [CHARGE_WIDTH-1:0] thr;

  // result register
  logic        rsp_valid;
  logic [15:0] rsp_hours;
  logic        rsp_store;
  logic [31:0] rsp_value;
  logic        rsp_cleared;

  // handshake and sequencing
  logic accept;
  logic rsp_load;
  logic req_ready;
  logic div_step;
  cac_pkg::cac_div_ctl_t div_ctl;

  // divider lanes
  logic        ratio_q;
  logic [19:0] int_rem;

  // accept-cycle update
  logic [CHARGE_WIDTH:0]    sum;
  logic [CHARGE_WIDTH-1:0]  sum_sat;
  logic [7:0]               hc_inc;
  logic                     hold_hit;
  logic [CHARGE_WIDTH+31:0] saved_ext;
  logic [CHARGE_WIDTH-1:0]  restore_val;
  logic [CHARGE_WIDTH-1:0]  charge_next;
  logic [7:0]               hold_count_next;

  // finishing cycle
  logic                     rem_ok;
  logic                     store_hit;
  logic [15:0]              hours;
  logic [CHARGE_WIDTH+31:0] charge_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_ratio        <= cac_pkg::RESET_DISPLAY_RATIO;
      checkpoint_interval  <= cac_pkg::RESET_CHECKPOINT_INTERVAL;
      checkpoint_tolerance <= cac_pkg::RESET_CHECKPOINT_TOLERANCE;
      hold_periods         <= cac_pkg::RESET_HOLD_PERIODS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        cac_pkg::CFG_DISPLAY_RATIO:        display_ratio        <= cfg.data[15:0];
        cac_pkg::CFG_CHECKPOINT_INTERVAL:  checkpoint_interval  <= cfg.data[19:0];
        cac_pkg::CFG_CHECKPOINT_TOLERANCE: checkpoint_tolerance <= cfg.data[19:0];
        cac_pkg::CFG_HOLD_PERIODS:         hold_periods         <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cac_pkg::ST_IDLE:   if (accept) state_next = cac_pkg::ST_DIVIDE;
      cac_pkg::ST_DIVIDE: if (bit_cnt == CNT_LAST) state_next = cac_pkg::ST_FINISH;
      cac_pkg::ST_FINISH: if (rsp_load) state_next = cac_pkg::ST_IDLE;
      default:            state_next = cac_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    div_step  = 1'b0;
    rsp_load  = 1'b0;
    unique case (state)
      cac_pkg::ST_IDLE:   req_ready = 1'b1;
      cac_pkg::ST_DIVIDE: div_step  = 1'b1;
      cac_pkg::ST_FINISH: rsp_load  = !rsp_valid || rsp.ready;
      default: ;
    endcase
  end

  assign req.ready = req_ready;
  assign accept    = req.valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // period and restore update, all in the accept cycle
  always_comb begin
    sum     = {1'b0, charge} + (CHARGE_WIDTH + 1)'(req.current);
    sum_sat = sum[CHARGE_WIDTH] ? CHARGE_MAX : sum[CHARGE_WIDTH-1:0];
    if (req.button_high) begin
      hc_inc = (hold_count == cac_pkg::HOLD_COUNT_MAX) ? cac_pkg::HOLD_COUNT_MAX
                                                       : hold_count + 8'd1;
    end else begin
      hc_inc = 8'd0;
    end
    hold_hit  = hc_inc >= hold_periods;
    saved_ext = {{CHARGE_WIDTH{1'b0}}, req.saved_charge & {32{req.saved_valid}}};
    restore_val = (|saved_ext[CHARGE_WIDTH+31:CHARGE_WIDTH]) ? CHARGE_MAX
                                                             : saved_ext[CHARGE_WIDTH-1:0];
    if (req.req_type == cac_pkg::REQ_RESTORE) begin
      charge_next     = restore_val;
      hold_count_next = hold_count;
    end else begin
      charge_next     = hold_hit ? '0 : sum_sat;
      hold_count_next = hold_hit ? 8'd0 : hc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge     <= '0;
      last_saved <= '0;
      hold_count <= 8'd0;
      bit_cnt    <= '0;
    end else begin
      if (accept) begin
        charge     <= charge_next;
        hold_count <= hold_count_next;
        bit_cnt    <= '0;
      end else if (div_step) begin
        bit_cnt <= bit_cnt + CNT_W'(1);
      end
      if (rsp_load && store_hit) begin
        last_saved <= charge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_period <= req.req_type == cac_pkg::REQ_PERIOD;
      clr       <= (req.req_type == cac_pkg::REQ_PERIOD) && hold_hit;
      shreg     <= charge_next;
      quo       <= 16'd0;
      quo_ovf   <= 1'b0;
    end else if (div_step) begin
      shreg   <= {shreg[CHARGE_WIDTH-2:0], 1'b0};
      quo     <= {quo[14:0], ratio_q};
      quo_ovf <= quo_ovf | quo[15];
      // charge and last_saved are steady while dividing; these settle for the finishing cycle
      gap     <= charge - last_saved;
      thr     <= CHARGE_WIDTH'(checkpoint_interval) - CHARGE_WIDTH'(checkpoint_tolerance);
    end
  end

  always_comb begin
    div_ctl.clear  = accept;
    div_ctl.step   = div_step;
    div_ctl.bit_in = shreg[CHARGE_WIDTH-1];
  end

  cac_div_lane #(.DIV_W(16)) u_ratio_lane (
    .clk     (clk),
    .ctl     (div_ctl),
    .divisor (display_ratio),
    .rem     (),
    .q_bit   (ratio_q)
  );

  cac_div_lane #(.DIV_W(20)) u_interval_lane (
    .clk     (clk),
    .ctl     (div_ctl),
    .divisor (checkpoint_interval),
    .rem     (int_rem),
    .q_bit   ()
  );

  // checkpoint test and display value
  always_comb begin
    // zero interval: remainder is the charge itself
    if (checkpoint_interval == 20'd0) begin
      rem_ok = charge <= CHARGE_WIDTH'(checkpoint_tolerance);
    end else begin
      rem_ok = int_rem <= checkpoint_tolerance;
    end
    store_hit = is_period && !clr && (charge != '0) && rem_ok &&
                (gap != '0) && (gap > thr);
    hours = (display_ratio == 16'd0 || quo_ovf) ? cac_pkg::HOURS_MAX : quo;
    charge_ext = {32'd0, charge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_hours   <= hours;
      rsp_store   <= store_hit;
      rsp_value   <= store_hit ? charge_ext[31:0] : 32'd0;
      rsp_cleared <= clr;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.hours_value   = rsp_hours;
  assign rsp.store_request = rsp_store;
  assign rsp.store_value   = rsp_value;
  assign rsp.cleared       = rsp_cleared;

  `ASSERT_IMPLY(a_store_not_cleared, clk, rst, rsp.valid && rsp.store_request, !rsp.cleared)
  `ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == cac_pkg::ST_DIVIDE && bit_cnt == '0)
  `ASSERT_NEXT(a_checkpoint_saved, clk, rst, rsp_load && store_hit, last_saved == charge)
  `ASSERT_IMPLY(a_clear_zeroes, clk, rst, state == cac_pkg::ST_FINISH && clr, charge == '0)

endmodule

/* src/cac_div_lane.sv */
// One lane of a restoring bit-serial divider: one dividend bit per step.
module cac_div_lane #(
  parameter int DIV_W = 16
) (
  input  logic                 clk,
  input  cac_pkg::cac_div_ctl_t ctl,
  input  logic [DIV_W-1:0]     divisor,
  output logic [DIV_W-1:0]     rem,
  output logic                 q_bit
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem, ctl.bit_in};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  assign q_bit = ge;

  // remainder stays below a nonzero divisor, so the low bits carry it
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

endmodule

/* tb/charge_accumulator_with_checkpoint_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the charge accumulator with hold-to-clear and checkpoints.
module charge_accumulator_with_checkpoint_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic        req_type;
    logic [15:0] current;
    logic        button_high;
    logic [31:0] saved_charge;
    logic        saved_valid;
  } req_item_t;

  typedef struct packed {
    logic [15:0] hours_value;
    logic        store_request;
    logic [31:0] store_value;
    logic        cleared;
  } reading_t;

  typedef struct packed {
    logic [15:0] ratio;
    logic [19:0] step;
    logic [19:0] slack;
    logic [7:0]  hold_limit;
  } setting_t;

  logic clk;
  logic rst;

  cac_req_if req_ch ();
  cac_rsp_if rsp_ch ();
  cac_cfg_if cfg_ch ();

  charge_accumulator_with_checkpoint uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Mirror of the block's registers and state
  logic [15:0] ratio_q      = cac_pkg::RESET_DISPLAY_RATIO;
  logic [19:0] step_q       = cac_pkg::RESET_CHECKPOINT_INTERVAL;
  logic [19:0] slack_q      = cac_pkg::RESET_CHECKPOINT_TOLERANCE;
  logic [7:0]  hold_limit_q = cac_pkg::RESET_HOLD_PERIODS;
  logic [31:0] charge_q     = '0;
  logic [31:0] saved_q      = '0;
  logic [7:0]  hold_cnt_q   = '0;

  reading_t readings_due[$];
  int       fault_count = 0;
  int       quiet_cycles = 0;
  int       press_left = 0;
  bit       brisk = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reading_t accumulate(input req_item_t it);
    reading_t    r;
    logic [32:0] sum;
    logic [31:0] rem;
    logic [31:0] climb;
    logic [31:0] threshold;
    logic [31:0] quot;
    r = '0;
    if (it.req_type == cac_pkg::REQ_RESTORE) begin
      charge_q = it.saved_valid ? it.saved_charge : 32'd0;
    end else begin
      if (it.button_high)
        hold_cnt_q = (hold_cnt_q == cac_pkg::HOLD_COUNT_MAX) ? cac_pkg::HOLD_COUNT_MAX
                                                             : hold_cnt_q + 8'd1;
      else
        hold_cnt_q = '0;
      sum = {1'b0, charge_q} + {17'd0, it.current};
      charge_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (hold_cnt_q >= hold_limit_q) begin
        charge_q = '0;
        hold_cnt_q = '0;
        r.cleared = 1'b1;
      end
      // zero interval: remainder is the charge itself
      rem = (step_q == '0) ? charge_q : charge_q % {12'd0, step_q};
      climb = charge_q - saved_q;
      threshold = {12'd0, step_q} - {12'd0, slack_q};
      if (charge_q != '0 && rem <= {12'd0, slack_q} && charge_q != saved_q &&
          climb > threshold) begin
        r.store_request = 1'b1;
        r.store_value = charge_q;
        saved_q = charge_q;
      end
    end
    quot = (ratio_q == '0) ? 32'hFFFF_FFFF : charge_q / {16'd0, ratio_q};
    r.hours_value = (quot > 32'h0000_FFFF) ? cac_pkg::HOURS_MAX : quot[15:0];
    return r;
  endfunction

  function automatic req_item_t period_item(input logic [15:0] amps, input logic btn);
    req_item_t it;
    it.req_type = cac_pkg::REQ_PERIOD;
    it.current = amps;
    it.button_high = btn;
    it.saved_charge = $urandom;
    it.saved_valid = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic req_item_t restore_item(input logic [31:0] saved, input logic ok);
    req_item_t it;
    it.req_type = cac_pkg::REQ_RESTORE;
    it.current = 16'($urandom);
    it.button_high = 1'($urandom_range(0, 1));
    it.saved_charge = saved;
    it.saved_valid = ok;
    return it;
  endfunction

  // Mostly periods, half of them with small steps so the charge lands near interval multiples,
  // button presses in runs, restores near saturation, just below the last checkpoint or random.
  function automatic req_item_t draw_item();
    req_item_t   it;
    logic [31:0] span;
    it = period_item(16'($urandom), 1'b0);
    if ($urandom_range(0, 99) < 12) begin
      it = restore_item($urandom, 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0: it.saved_charge = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        1: it.saved_charge = saved_q - $urandom_range(0, 300);
        default: ;
      endcase
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        span = (step_q == '0) ? 32'd64 : {12'd0, step_q} / 8;
        if (span > 32'd65535)
          span = 32'd65535;
        it.current = 16'($urandom_range(0, span));
      end
      if (press_left == 0 && $urandom_range(0, 7) == 0)
        press_left = $urandom_range(1, (hold_limit_q < 8) ? hold_limit_q + 1 : 9);
      if (press_left > 0) begin
        it.button_high = 1'b1;
        press_left--;
      end
    end
    return it;
  endfunction

  // valid stays high after an item unless a gap follows or the sender pauses
  task automatic send_item(input req_item_t it);
    int gap;
    gap = brisk ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= it.req_type;
    req_ch.current <= it.current;
    req_ch.button_high <= it.button_high;
    req_ch.saved_charge <= it.saved_charge;
    req_ch.saved_valid <= it.saved_valid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    readings_due.push_back(accumulate(it));
  endtask

  task automatic hold_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
  endtask

  task automatic write_reg(input cac_pkg::cac_cfg_index_t idx,
                           input logic [cac_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      cac_pkg::CFG_DISPLAY_RATIO:        ratio_q = val[15:0];
      cac_pkg::CFG_CHECKPOINT_INTERVAL:  step_q = val[19:0];
      cac_pkg::CFG_CHECKPOINT_TOLERANCE: slack_q = val[19:0];
      cac_pkg::CFG_HOLD_PERIODS:         hold_limit_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input setting_t s);
    write_reg(cac_pkg::CFG_DISPLAY_RATIO, {4'd0, s.ratio});
    write_reg(cac_pkg::CFG_CHECKPOINT_INTERVAL, s.step);
    write_reg(cac_pkg::CFG_CHECKPOINT_TOLERANCE, s.slack);
    write_reg(cac_pkg::CFG_HOLD_PERIODS, {12'd0, s.hold_limit});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic log_fault(input string what, input reading_t want, input reading_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected hours %0d store %0b/%0h cleared %0b, got hours %0d store %0b/%0h cleared %0b",
               what, want.hours_value, want.store_request, want.store_value, want.cleared,
               got.hours_value, got.store_request, got.store_value, got.cleared);
  endtask

  task automatic test_reset_values();
    send_item(period_item(16'd0, 1'b0));
    send_item(period_item(16'd36000, 1'b0));      // lands on an interval multiple
    send_item(period_item(16'hFFFF, 1'b0));
    send_item(period_item(16'd10, 1'b1));
    send_item(period_item(16'd10, 1'b1));
    send_item(period_item(16'd10, 1'b1));         // third press clears
    send_item(restore_item(32'd123, 1'b0));       // blank store
    send_item(restore_item(32'hFFFF_FFFF, 1'b1));
    send_item(period_item(16'hFFFF, 1'b0));       // charge saturates
    send_item(period_item(16'd0, 1'b1));
    hold_for_results();
  endtask

  task automatic test_degenerate_registers();
    load_setting('{16'd0, 20'd0, 20'd20, 8'd4});
    send_item(restore_item(32'd0, 1'b1));
    send_item(period_item(16'd5, 1'b0));
    send_item(period_item(16'd0, 1'b0));
    send_item(period_item(16'd7, 1'b0));
    hold_for_results();
    // zero hold limit: every period clears
    load_setting('{16'hFFFF, 20'd100, 20'd10, 8'd0});
    send_item(period_item(16'd100, 1'b0));
    send_item(period_item(16'hFFFF, 1'b1));
    hold_for_results();
  endtask

  task automatic test_wrapped_threshold();
    load_setting('{16'd3600, 20'd100, 20'd10, 8'd3});
    send_item(restore_item(32'd0, 1'b0));
    send_item(period_item(16'd100, 1'b0));
    send_item(restore_item(32'd95, 1'b1));        // just below the last checkpoint
    hold_for_results();
    // tolerance above interval: threshold wraps, a small step back counts
    load_setting('{16'd3600, 20'd100, 20'd200, 8'd3});
    send_item(period_item(16'd0, 1'b0));
    hold_for_results();
  endtask

  task automatic test_random_settings();
    setting_t plan[8];
    plan[0] = '{cac_pkg::RESET_DISPLAY_RATIO, cac_pkg::RESET_CHECKPOINT_INTERVAL,
                cac_pkg::RESET_CHECKPOINT_TOLERANCE, cac_pkg::RESET_HOLD_PERIODS};
    plan[1] = '{16'd1, 20'd100, 20'd10, 8'd1};
    plan[2] = '{16'hFFFF, 20'hFFFFF, 20'd0, 8'hFF};
    plan[3] = '{16'd7, 20'd50, 20'd60, 8'd5};
    plan[4] = '{16'd300, 20'd4096, 20'd500, 8'd2};
    plan[5] = '{16'd0, 20'd0, 20'hFFFFF, 8'd4};
    for (int k = 6; k < 8; k++) begin
      plan[k].ratio = 16'($urandom_range(1, 65535));
      plan[k].step = 20'($urandom_range(1, 5000));
      plan[k].slack = 20'($urandom_range(0, 1000));
      plan[k].hold_limit = 8'($urandom_range(1, 6));
    end
    for (int p = 0; p < 8; p++) begin
      load_setting(plan[p]);
      press_left = 0;
      for (int i = 0; i < 56; i++) begin
        if (i % 28 == 0)
          brisk = ($urandom_range(0, 2) == 0);
        if (i == 40 && p % 2 == 0)
          hold_for_results();
        send_item(draw_item());
      end
      hold_for_results();
    end
    brisk = 1'b0;
  endtask

  initial begin : result_check
    int       stall;
    reading_t got;
    reading_t want;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = brisk ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.hours_value = rsp_ch.hours_value;
      got.store_request = rsp_ch.store_request;
      got.store_value = rsp_ch.store_value;
      got.cleared = rsp_ch.cleared;
      if (readings_due.size() == 0) begin
        log_fault("result with nothing due", '0, got);
      end else begin
        want = readings_due.pop_front();
        if (got.hours_value !== want.hours_value || got.store_request !== want.store_request ||
            got.store_value !== want.store_value || got.cleared !== want.cleared)
          log_fault("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("charge_accumulator_with_checkpoint_tb failed");
      $finish;
    end
  end

  initial begin : run
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= cac_pkg::REQ_PERIOD;
    req_ch.current <= '0;
    req_ch.button_high <= 1'b0;
    req_ch.saved_charge <= '0;
    req_ch.saved_valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= cac_pkg::CFG_DISPLAY_RATIO;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_degenerate_registers();
    test_wrapped_threshold();
    test_random_settings();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && readings_due.size() == 0)
      $display("charge_accumulator_with_checkpoint_tb passed");
    else
      $display("charge_accumulator_with_checkpoint_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/cac_pkg.sv
src/cac_ifs.sv
src/cac_div_lane.sv
src/charge_accumulator_with_checkpoint.sv
tb/charge_accumulator_with_checkpoint_tb.sv
